// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication with reset disable.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Clocked implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hw/rtl/anri_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest-ray index package
// Shared constants, commands, status codes and state encoding.
// ----------------------------------------------------------------------------
package anri_pkg;
   localparam int NUM_BINS_DEF = 3600;
   localparam int MAX_RAY_COUNT_DEF = 720;
   localparam int CSR_WIDTH = 12;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0, CMD_RECORD = 2'd1, CMD_LOOKUP = 2'd2, CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0, STATUS_NO_MATCH = 2'd1, STATUS_FULL = 2'd2
   } status_type;

   localparam logic [1:0] CSR_AZ_TOL = 2'd0;
   localparam logic [1:0] CSR_EL_TOL = 2'd1;
   localparam logic [1:0] CSR_TM_TOL = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_REC_BIN, ST_REC_MUL, ST_FILL_RD, ST_FILL_WAIT,
      ST_FILL_HELD, ST_FILL_CMP, ST_LK_BIN, ST_LK_MUL, ST_LK_RD, ST_LK_RAY,
      ST_LK_CMP, ST_DONE
   } state_type;
endpackage

// ----- hw/rtl/anri_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface anri_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] azimuth_code;
   logic [15:0] elevation_code;
   logic [31:0] time_seconds;
   modport source (output valid, cmd, azimuth_code, elevation_code, time_seconds,
      input ready);
   modport sink (input valid, cmd, azimuth_code, elevation_code, time_seconds,
      output ready);
endinterface

// ----- hw/rtl/anri_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface anri_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [9:0] ray_index;
   modport source (output valid, status, ray_index, input ready);
   modport sink (input valid, status, ray_index, output ready);
endinterface

// ----- hw/rtl/azimuth_nearest_ray_index_unit.sv -----
// ----------------------------------------------------------------------------
// Azimuth nearest-ray index unit
// Clears, records rays and answers nearest-ray lookups over a table of azimuth bins.
// ----------------------------------------------------------------------------
// A record stores the ray and claims its own bin, then fills the window of 2*tol+1 bins
// around that bin, with tol the azimuth tolerance register. Each bin of the fill window
// takes a table read, a ray read, a wait for the ray data and a distance compare on the
// shared subtract-and-compare unit, and the bin table is a single-port memory. A response
// beat and the return to idle follow. A record into a full store or an unused command goes
// straight to the response. A clear sweeps the bin table one entry a cycle. The block also
// runs this sweep after reset, during which it accepts no request and gives no response.
// Each request gives one response, which is held while the receiver stalls it; the next
// request is taken once that response has been delivered.
module azimuth_nearest_ray_index_unit #(
   parameter int NUM_BINS = anri_pkg::NUM_BINS_DEF,
   parameter int MAX_RAY_COUNT = anri_pkg::MAX_RAY_COUNT_DEF
) (
   input  logic clock,
   input  logic reset,
   anri_req_if.sink req,
   anri_rsp_if.source rsp,
   input  logic csr_write_enable,
   input  logic [anri_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [anri_pkg::CSR_WIDTH-1:0] csr_write_data
);
   localparam int BW = $clog2(NUM_BINS + 1);
   localparam int RW = $clog2(MAX_RAY_COUNT + 1);
   localparam int DW = BW + 17;

   // Configuration registers.
   logic [7:0]  az_tol_ff;
   logic [11:0] el_tol_ff, tm_tol_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         az_tol_ff <= 8'd5;
         el_tol_ff <= 12'd91;
         tm_tol_ff <= 12'd60;
      end else if (csr_write_enable) begin
         case (csr_index)
            anri_pkg::CSR_AZ_TOL: az_tol_ff <= csr_write_data[7:0];
            anri_pkg::CSR_EL_TOL: el_tol_ff <= csr_write_data;
            anri_pkg::CSR_TM_TOL: tm_tol_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Memories: bin table (valid + index) and ray store.
   logic [RW:0]   bin_mem [NUM_BINS];
   logic [15:0]   az_mem [MAX_RAY_COUNT];
   logic [15:0]   el_mem [MAX_RAY_COUNT];
   logic [31:0]   tm_mem [MAX_RAY_COUNT];

   anri_pkg::state_type state_ff, state_in;
   logic [1:0]  cmd_ff;
   logic [15:0] az_ff, el_ff;
   logic [31:0] tm_ff;
   logic [RW-1:0] count_ff, count_in, ray_ff;
   logic [BW-1:0] bin_ff, bin_in, own_ff, cur_ff, cur_in;
   logic [8:0]  k_ff, k_in;
   logic [BW+15:0] prod_ff;
   logic [DW-1:0] new_d_ff, new_d_in;
   logic [RW:0] entry_ff;
   logic [15:0] held_az_ff;
   logic [15:0] rel_ff;
   logic [31:0] rtm_ff;
   logic [1:0]  st_ff, st_in;
   logic [RW-1:0] idx_ff, idx_in;

   // Table port control.
   logic          tbl_we;
   logic [BW-1:0] tbl_addr;
   logic [RW:0]   tbl_wdata;
   always_ff @(posedge clock) begin
      if (tbl_we) bin_mem[tbl_addr] <= tbl_wdata;
      entry_ff <= bin_mem[tbl_addr];
   end

   // Ray store write on record, reads for compare and lookup.
   logic rec_we;
   logic [RW-1:0] ray_rd;
   always_ff @(posedge clock) begin
      if (rec_we) begin
         az_mem[count_ff[RW-1:0]] <= az_ff;
         el_mem[count_ff[RW-1:0]] <= el_ff;
         tm_mem[count_ff[RW-1:0]] <= tm_ff;
      end
      held_az_ff <= az_mem[ray_rd];
      rel_ff <= el_mem[ray_rd];
      rtm_ff <= tm_mem[ray_rd];
   end

   // Bin rounding from the registered product.
   logic [BW+15:0] prod_r;
   logic [BW-1:0] round_bin;
   assign prod_r = prod_ff + (BW+16)'(32768);
   always_comb begin
      round_bin = prod_r[BW+15:16];
      if (round_bin >= BW'(NUM_BINS)) round_bin = '0;
   end

   // Shared distance unit: |bin*65536 - code*NUM_BINS|.
   logic [15:0] dist_code;
   logic [DW-1:0] dist_a, dist_b, dist_out;
   assign dist_a = {1'b0, cur_ff, 16'd0};
   assign dist_b = DW'(dist_code) * DW'(NUM_BINS);
   assign dist_out = (dist_a >= dist_b) ? dist_a - dist_b : dist_b - dist_a;

   // Window bin for step k: (own + N + k - tol) mod N, done by compare.
   logic [BW+1:0] win;
   logic [BW-1:0] win_bin;
   always_comb begin
      win = (BW+2)'(own_ff) + (BW+2)'(k_ff) + (BW+2)'(NUM_BINS) - (BW+2)'(az_tol_ff);
      if (win >= (BW+2)'(2*NUM_BINS)) win = win - (BW+2)'(2*NUM_BINS);
      else if (win >= (BW+2)'(NUM_BINS)) win = win - (BW+2)'(NUM_BINS);
      win_bin = win[BW-1:0];
   end

   logic [RW-1:0] held;
   logic [16:0] de;
   logic [32:0] dt;
   always_comb begin
      held = entry_ff[RW-1:0];
      if (held >= RW'(MAX_RAY_COUNT)) held = '0;
      de = (el_ff > rel_ff) ? 17'(el_ff - rel_ff) : 17'(rel_ff - el_ff);
      dt = (tm_ff > rtm_ff) ? 33'(tm_ff - rtm_ff) : 33'(rtm_ff - tm_ff);
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      bin_in = bin_ff;
      cur_in = cur_ff;
      k_in = k_ff;
      count_in = count_ff;
      new_d_in = new_d_ff;
      st_in = st_ff;
      idx_in = idx_ff;
      tbl_we = 1'b0;
      tbl_addr = cur_ff;
      tbl_wdata = {1'b1, ray_ff};
      rec_we = 1'b0;
      ray_rd = held;
      dist_code = az_ff;
      case (state_ff)
         anri_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               st_in = anri_pkg::STATUS_NO_MATCH;
               idx_in = '0;
               bin_in = '0;
               case (anri_pkg::cmd_type'(req.cmd))
                  anri_pkg::CMD_CLEAR: begin
                     state_in = anri_pkg::ST_CLEAR;
                     count_in = '0;
                     st_in = anri_pkg::STATUS_OK;
                  end
                  anri_pkg::CMD_RECORD: begin
                     if (count_ff >= RW'(MAX_RAY_COUNT)) begin
                        st_in = anri_pkg::STATUS_FULL;
                        state_in = anri_pkg::ST_DONE;
                     end else begin
                        st_in = anri_pkg::STATUS_OK;
                        idx_in = count_ff;
                        state_in = anri_pkg::ST_REC_BIN;
                     end
                  end
                  anri_pkg::CMD_LOOKUP: state_in = anri_pkg::ST_LK_BIN;
                  default: state_in = anri_pkg::ST_DONE;
               endcase
            end
         end
         anri_pkg::ST_CLEAR: begin
            tbl_we = 1'b1;
            tbl_addr = bin_ff;
            tbl_wdata = '0;
            bin_in = bin_ff + 1'b1;
            // The sweep after reset has no request to answer.
            if (bin_ff == BW'(NUM_BINS - 1)) begin
               if (cmd_ff == anri_pkg::CMD_CLEAR) state_in = anri_pkg::ST_DONE;
               else state_in = anri_pkg::ST_IDLE;
            end
         end
         anri_pkg::ST_REC_BIN: begin
            rec_we = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = anri_pkg::ST_REC_MUL;
         end
         anri_pkg::ST_REC_MUL: begin
            tbl_we = 1'b1;
            tbl_addr = round_bin;
            k_in = '0;
            state_in = anri_pkg::ST_FILL_RD;
         end
         anri_pkg::ST_FILL_RD: begin
            cur_in = win_bin;
            tbl_addr = win_bin;
            state_in = anri_pkg::ST_FILL_WAIT;
         end
         anri_pkg::ST_FILL_WAIT: begin
            new_d_in = dist_out;
            state_in = anri_pkg::ST_FILL_HELD;
         end
         anri_pkg::ST_FILL_HELD: state_in = anri_pkg::ST_FILL_CMP;
         anri_pkg::ST_FILL_CMP: begin
            dist_code = held_az_ff;
            if (!entry_ff[RW] || new_d_ff < dist_out) tbl_we = 1'b1;
            k_in = k_ff + 1'b1;
            if (k_ff == {az_tol_ff, 1'b0}) state_in = anri_pkg::ST_DONE;
            else state_in = anri_pkg::ST_FILL_RD;
         end
         anri_pkg::ST_LK_BIN: state_in = anri_pkg::ST_LK_MUL;
         anri_pkg::ST_LK_MUL: begin
            // Keep the table port on the query bin until the compare.
            cur_in = round_bin;
            tbl_addr = round_bin;
            state_in = anri_pkg::ST_LK_RD;
         end
         anri_pkg::ST_LK_RD: state_in = anri_pkg::ST_LK_RAY;
         anri_pkg::ST_LK_RAY: state_in = anri_pkg::ST_LK_CMP;
         anri_pkg::ST_LK_CMP: begin
            if (entry_ff[RW] && entry_ff[RW-1:0] < RW'(MAX_RAY_COUNT) &&
                de <= 17'(el_tol_ff) && dt <= 33'(tm_tol_ff)) begin
               st_in = anri_pkg::STATUS_OK;
               idx_in = entry_ff[RW-1:0];
            end
            state_in = anri_pkg::ST_DONE;
         end
         anri_pkg::ST_DONE: if (rsp.ready) state_in = anri_pkg::ST_IDLE;
         default: state_in = anri_pkg::ST_IDLE;
      endcase
   end

   assign req.ready = (state_ff == anri_pkg::ST_IDLE) && !reset;

   // State registers and request capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= anri_pkg::ST_CLEAR;
         bin_ff <= '0;
         count_ff <= '0;
         cmd_ff <= anri_pkg::CMD_NONE;
      end else begin
         state_ff <= state_in;
         bin_ff <= bin_in;
         count_ff <= count_in;
         st_ff <= st_in;
         idx_ff <= idx_in;
         if (req.valid && req.ready) begin
            cmd_ff <= req.cmd;
            az_ff <= req.azimuth_code;
            el_ff <= req.elevation_code;
            tm_ff <= req.time_seconds;
            prod_ff <= (BW+16)'(req.azimuth_code) * (BW+16)'(NUM_BINS);
            ray_ff <= count_ff;
         end
      end
      cur_ff <= cur_in;
      k_ff <= k_in;
      new_d_ff <= new_d_in;
      if (state_ff == anri_pkg::ST_REC_MUL) own_ff <= round_bin;
   end

   assign rsp.valid = (state_ff == anri_pkg::ST_DONE);
   assign rsp.status = (state_ff == anri_pkg::ST_DONE) ? st_ff : anri_pkg::STATUS_OK;
   assign rsp.ray_index = 10'(idx_ff);
endmodule

// ----- hw/rtl/anri_checker.sv -----
// ----------------------------------------------------------------------------
// Nearest-ray index port checker
// Watches the top level's ports for ordering of request and response beats and for their status and index values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module anri_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_status,
   input logic [9:0] rsp_ray_index
);
   logic rsp_not_ok;
   logic status_known;
   assign rsp_not_ok = rsp_valid && (rsp_status != anri_pkg::STATUS_OK);
   assign status_known = (rsp_status <= anri_pkg::STATUS_FULL);

   // No request is taken while a response is pending.
   `ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready, "ready while response pending")
   // A response that is not ok carries index zero.
   `ASSERT_IMPL(a_idx_zero, clock, reset, rsp_not_ok, rsp_ray_index == 10'd0, "nonzero index")
   // A stalled response beat stays until it is taken.
   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   // Only the defined status codes appear.
   `ASSERT_IMPL(a_status, clock, reset, rsp_valid, status_known, "bad status")
endmodule

bind azimuth_nearest_ray_index_unit anri_checker u_anri_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
   .rsp_ray_index(rsp.ray_index)
);
